FILE: src/cursor_pixel_to_rgba_macros.svh
// assertion macros for the cursor pixel converter
`ifndef CURSOR_PIXEL_TO_RGBA_MACROS_SVH
`define CURSOR_PIXEL_TO_RGBA_MACROS_SVH

// concurrent assertion on a given clock, disabled while reset is low
`define CPR_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("cursor_pixel_to_rgba assertion failed");

// same on the block clock and reset
`define CPR_ASSERT(lbl, prop) `CPR_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: src/cpr_pkg.sv
// shared types and constants of the cursor pixel converter
package cpr_pkg;

  localparam int unsigned MAX_WIDTH       = 1024;
  localparam int unsigned PALETTE_ENTRIES = 16;

  localparam int unsigned PixW     = 32;
  localparam int unsigned SlotW    = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CurWidthW = 11;
  localparam int unsigned FmtW     = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = CurWidthW;

  localparam logic [PixW-1:0] CheckerOdd  = 32'hc0303030;
  localparam logic [PixW-1:0] CheckerEven = 32'h30505050;
  localparam logic [PixW-1:0] White32     = 32'h00ffffff;
  localparam logic [15:0]     White16     = 16'h7fff;
  localparam logic [PixW-1:0] AlphaOpaque = 32'hff000000;

  typedef enum logic [FmtW-1:0] {
    FMT_ALPHA   = 2'd0,
    FMT_COLOR32 = 2'd1,
    FMT_COLOR16 = 2'd2,
    FMT_COLOR4  = 2'd3
  } pix_fmt_e;

  typedef enum logic {
    KIND_PIXEL     = 1'b0,
    KIND_PAL_WRITE = 1'b1
  } item_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PIXEL_FORMAT = 1'b0,
    CFG_CURSOR_WIDTH = 1'b1
  } cfg_reg_e;

  // position tracker control from the datapath
  typedef struct packed {
    logic advance;
    logic first;
    logic last;
  } pos_ctrl_t;

endpackage

FILE: src/cpr_ifs.sv
// stream interfaces for cursor pixels in and rgba pixels out
interface cpr_pix_if;
  import cpr_pkg::*;

  logic                 valid;
  logic                 ready;
  item_kind_e           kind;
  logic [PixW-1:0]      pixel_value;
  logic                 mask_bit;
  logic [SlotW-1:0]     palette_slot;
  logic                 first_pixel;
  logic                 last_pixel;

  modport source (
    output valid, kind, pixel_value, mask_bit, palette_slot, first_pixel, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, kind, pixel_value, mask_bit, palette_slot, first_pixel, last_pixel,
    output ready
  );
endinterface

interface cpr_rgba_if;
  import cpr_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] rgba;
  logic            end_of_cursor;

  modport source (output valid, rgba, end_of_cursor, input ready);
  modport sink   (input valid, rgba, end_of_cursor, output ready);
endinterface

FILE: src/cpr_palette.sv
// 16-entry palette register file, one write port and one combinational read
module cpr_palette (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [cpr_pkg::SlotW-1:0] waddr_i,
  input  logic [cpr_pkg::PixW-1:0]  wdata_i,
  input  logic [cpr_pkg::SlotW-1:0] raddr_i,
  output logic [cpr_pkg::PixW-1:0]  rdata_o
);
  import cpr_pkg::*;

  logic [PixW-1:0] pal_q [PALETTE_ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pal_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = pal_q[raddr_i];

endmodule

FILE: src/cpr_pos.sv
// column counter and row parity, gives the checkerboard phase of the current pixel
module cpr_pos #(
  parameter int unsigned MaxWidth = cpr_pkg::MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cpr_pkg::CurWidthW-1:0] cursor_width_i,
  input  cpr_pkg::pos_ctrl_t            ctrl_i,
  output logic                         checker_odd_o
);
  import cpr_pkg::*;

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned EffW = $clog2(MaxWidth + 1);
  localparam int unsigned CmpW = (EffW > CurWidthW) ? EffW : CurWidthW;

  logic [ColW-1:0] col_q, col_d;
  logic            par_q, par_d;
  logic [CmpW-1:0] cw_ext, eff_width, col_inc;
  logic [ColW-1:0] col_start, col_cur;
  logic            par_start, wrap;

  always_comb begin
    cw_ext = CmpW'(cursor_width_i);
    if (cw_ext == '0) begin
      eff_width = CmpW'(1);
    end else if (cw_ext > CmpW'(MaxWidth)) begin
      eff_width = CmpW'(MaxWidth);
    end else begin
      eff_width = cw_ext;
    end

    col_start = ctrl_i.first ? '0 : col_q;
    par_start = ctrl_i.first ? 1'b0 : par_q;
    // width may have shrunk since the column was stored
    col_cur   = (CmpW'(col_start) >= eff_width) ? '0 : col_start;
    col_inc   = CmpW'(col_cur) + CmpW'(1);
    wrap      = col_inc >= eff_width;

    col_d = col_q;
    par_d = par_q;
    if (ctrl_i.advance) begin
      if (ctrl_i.last) begin
        col_d = '0;
        par_d = 1'b0;
      end else if (wrap) begin
        col_d = '0;
        par_d = ~par_start;
      end else begin
        col_d = col_inc[ColW-1:0];
        par_d = par_start;
      end
    end
  end

  assign checker_odd_o = col_cur[0] ^ par_start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      par_q <= 1'b0;
    end else begin
      col_q <= col_d;
      par_q <= par_d;
    end
  end

endmodule

FILE: src/cpr_conv.sv
// per-pixel color conversion, mask handling and red/blue swap
module cpr_conv (
  input  cpr_pkg::pix_fmt_e         fmt_i,
  input  logic [cpr_pkg::PixW-1:0]  pixel_value_i,
  input  logic [cpr_pkg::PixW-1:0]  pal_word_i,
  input  logic                      mask_bit_i,
  input  logic                      checker_odd_i,
  output logic [cpr_pkg::PixW-1:0]  rgba_o
);
  import cpr_pkg::*;

  logic [PixW-1:0] checker_word, color, result;
  logic [15:0]     p16;
  logic            white;

  always_comb begin
    checker_word = checker_odd_i ? CheckerOdd : CheckerEven;
    p16     = pixel_value_i[15:0];
    color   = pixel_value_i;
    white   = 1'b0;
    case (fmt_i)
      FMT_COLOR32: begin
        color = pixel_value_i;
        white = pixel_value_i == White32;
      end
      FMT_COLOR16: begin
        // rgb555 to 8 bits per channel, low bits left zero
        color = {8'h00, p16[14:10], 3'b000, p16[9:5], 3'b000, p16[4:0], 3'b000};
        white = p16 == White16;
      end
      FMT_COLOR4: begin
        color = pal_word_i;
        white = pal_word_i == White32;
      end
      default: begin
        color = pixel_value_i;
        white = 1'b0;
      end
    endcase

    if (fmt_i == FMT_ALPHA) begin
      result = pixel_value_i;
    end else if (mask_bit_i && white) begin
      result = checker_word;
    end else begin
      result = mask_bit_i ? color : (color | AlphaOpaque);
    end

    rgba_o = {result[31:24], result[7:0], result[15:8], result[23:16]};
  end

endmodule

FILE: src/cursor_pixel_to_rgba.sv
// Cursor pixel to RGBA converter. Takes one item per clock while the result
// side keeps up: a pixel item (kind 0) gives one rgba result, a palette
// write (kind 1) gives none and loads one of the 16 palette words. A pixel
// item passes an input register and then a result register before its
// result is offered; a palette write leaves from the input register. The
// only stall comes from a full result register that is not being taken.
// Position restarts on first_pixel and after last_pixel. Configuration
// writes belong between cursors, with no item in flight; a color4 lookup
// of a palette word never written returns an undefined color.
module cursor_pixel_to_rgba #(
  parameter int unsigned MaxWidth = cpr_pkg::MAX_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cpr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cpr_pkg::CfgDataW-1:0] cfg_wdata_i,
  cpr_pix_if.sink                      px_i,
  cpr_rgba_if.source                   rgba_o
);
  import cpr_pkg::*;

  pix_fmt_e             fmt_q;
  logic [CurWidthW-1:0] cw_q;

  logic                 s1_valid_q;
  item_kind_e           s1_kind_q;
  logic [PixW-1:0]      s1_pv_q;
  logic                 s1_mask_q;
  logic [SlotW-1:0]     s1_slot_q;
  logic                 s1_first_q;
  logic                 s1_last_q;

  logic                 out_valid_q;
  logic [PixW-1:0]      out_rgba_q;
  logic                 out_eoc_q;

  logic                 out_free, s1_fire, s1_is_pix, in_fire;
  logic [PixW-1:0]      pal_word, conv_rgba;
  logic                 checker_odd;
  pos_ctrl_t            pos_ctrl;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_ALPHA;
      cw_q  <= CurWidthW'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_PIXEL_FORMAT: fmt_q <= pix_fmt_e'(cfg_wdata_i[FmtW-1:0]);
        CFG_CURSOR_WIDTH: cw_q  <= cfg_wdata_i[CurWidthW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || rgba_o.ready;
  assign s1_is_pix  = s1_kind_q == KIND_PIXEL;
  // palette writes retire without needing the result register
  assign s1_fire    = s1_valid_q && (!s1_is_pix || out_free);
  assign px_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = px_i.valid && px_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (px_i.ready) begin
      s1_valid_q <= px_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= px_i.kind;
      s1_pv_q    <= px_i.pixel_value;
      s1_mask_q  <= px_i.mask_bit;
      s1_slot_q  <= px_i.palette_slot;
      s1_first_q <= px_i.first_pixel;
      s1_last_q  <= px_i.last_pixel;
    end
  end

  cpr_palette u_palette (
    .clk_i   (clk_i),
    .we_i    (s1_fire && !s1_is_pix),
    .waddr_i (s1_slot_q),
    .wdata_i (s1_pv_q),
    .raddr_i (s1_pv_q[SlotW-1:0]),
    .rdata_o (pal_word)
  );

  assign pos_ctrl.advance = s1_fire && s1_is_pix;
  assign pos_ctrl.first   = s1_first_q;
  assign pos_ctrl.last    = s1_last_q;

  cpr_pos #(
    .MaxWidth (MaxWidth)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cursor_width_i (cw_q),
    .ctrl_i         (pos_ctrl),
    .checker_odd_o  (checker_odd)
  );

  cpr_conv u_conv (
    .fmt_i         (fmt_q),
    .pixel_value_i (s1_pv_q),
    .pal_word_i    (pal_word),
    .mask_bit_i    (s1_mask_q),
    .checker_odd_i (checker_odd),
    .rgba_o        (conv_rgba)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_fire && s1_is_pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_is_pix) begin
      out_rgba_q <= conv_rgba;
      out_eoc_q  <= s1_last_q;
    end
  end

  assign rgba_o.valid         = out_valid_q;
  assign rgba_o.rgba          = out_rgba_q;
  assign rgba_o.end_of_cursor = out_eoc_q;

endmodule

FILE: src/cpr_checker.sv
// port-level checks of the cursor pixel converter and their bind
`include "cursor_pixel_to_rgba_macros.svh"

module cpr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [cpr_pkg::PixW-1:0] out_rgba_i,
  input logic                     out_eoc_i
);
  import cpr_pkg::*;

  logic out_stall;

  assign out_stall = out_valid_i && !out_ready_i;

  // a stalled result keeps its valid and payload
  `CPR_ASSERT(a_out_hold, out_stall |=> out_valid_i && $stable(out_rgba_i) && $stable(out_eoc_i))

  // the input side stalls only behind a blocked result
  `CPR_ASSERT(a_stall_cause, !in_ready_i |-> out_stall)

  // a fresh result comes from an input transfer through the input and result registers
  `CPR_ASSERT(a_out_origin, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))

endmodule

bind cursor_pixel_to_rgba cpr_checker u_cpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (px_i.valid),
  .in_ready_i  (px_i.ready),
  .out_valid_i (rgba_o.valid),
  .out_ready_i (rgba_o.ready),
  .out_rgba_i  (rgba_o.rgba),
  .out_eoc_i   (rgba_o.end_of_cursor)
);
